@@ hw/rtl/ewsd_pkg.sv @@
// ----------------------------------------------------------------------------
// ewsd_pkg - shared types and constants
// Register map, command codes, reset values and the structs passed between
// the top level and the update datapath of the weight stability detector.
// ----------------------------------------------------------------------------
package ewsd_pkg;

  // register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_ALPHA  = 2'd0,
    REG_SETTLE = 2'd1,
    REG_BREAK  = 2'd2,
    REG_STIME  = 2'd3
  } reg_idx_t;

  localparam int unsigned ADDR_W = 4;

  // command codes carried in tuser
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TARE   = 1'b1;

  // register reset values
  localparam logic [15:0] ALPHA_RST  = 16'd13107;  // ~0.2 in Q0.16
  localparam logic [15:0] SETTLE_RST = 16'd77;     // ~0.3 g in Q8
  localparam logic [15:0] BREAK_RST  = 16'd512;    // 2.0 g in Q8
  localparam logic [31:0] STIME_RST  = 32'd1500;   // ms

  typedef struct packed {
    logic [15:0] alpha_q16;
    logic [15:0] settle_threshold;
    logic [15:0] break_threshold;
    logic [31:0] settle_time_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] filter_value;
    logic               first_pending;
    logic signed [31:0] reference_weight;
    logic        [31:0] window_start_ms;
    logic               stable_state;
    logic signed [31:0] latched_weight;
  } state_t;

  typedef struct packed {
    logic               command;
    logic signed [31:0] raw_weight;
    logic        [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic signed [31:0] filtered_weight;
    logic signed [31:0] stable_value;
    logic               stable_flag;
  } result_t;

endpackage

@@ hw/rtl/ewsd_core.sv @@
// ----------------------------------------------------------------------------
// ewsd_core - per-word update datapath
// EMA step, settle window, break check and tare for one word; gives the next
// state and the result word from the current state and configuration.
// ----------------------------------------------------------------------------
module ewsd_core (
  input  ewsd_pkg::cfg_t    cfg,
  input  ewsd_pkg::state_t  cur,
  input  ewsd_pkg::item_t   item,
  output ewsd_pkg::state_t  nxt,
  output ewsd_pkg::result_t res
);
  import ewsd_pkg::*;

  logic signed [32:0] diff;
  logic signed [49:0] prod;
  logic signed [49:0] step;
  logic signed [31:0] filt;
  logic signed [32:0] dev_ref;
  logic signed [32:0] dev_lat;
  logic        [32:0] abs_ref;
  logic        [32:0] abs_lat;
  logic        [31:0] elapsed;

  // EMA: filter + floor(alpha * (raw - filter) / 2^16), stays in 32 bits
  assign diff = 33'(item.raw_weight) - 33'(cur.filter_value);
  assign prod = 50'(diff) * $signed({34'd0, cfg.alpha_q16});
  assign step = prod >>> 16;
  assign filt = cur.first_pending ? item.raw_weight
                                  : cur.filter_value + step[31:0];

  assign dev_ref = 33'(filt) - 33'(cur.reference_weight);
  assign dev_lat = 33'(filt) - 33'(cur.latched_weight);
  assign abs_ref = dev_ref[32] ? 33'(-dev_ref) : 33'(dev_ref);
  assign abs_lat = dev_lat[32] ? 33'(-dev_lat) : 33'(dev_lat);
  assign elapsed = item.now_ms - cur.window_start_ms;

  always_comb begin
    nxt = cur;
    if (item.command == CMD_TARE) begin
      nxt.first_pending    = 1'b1;
      nxt.stable_state     = 1'b0;
      nxt.reference_weight = '0;
      nxt.window_start_ms  = item.now_ms;
    end else begin
      nxt.filter_value  = filt;
      nxt.first_pending = 1'b0;
      if (!cur.stable_state) begin
        if (abs_ref > {17'd0, cfg.settle_threshold}) begin
          nxt.reference_weight = filt;
          nxt.window_start_ms  = item.now_ms;
        end else if (elapsed > cfg.settle_time_ms) begin
          nxt.stable_state   = 1'b1;
          nxt.latched_weight = filt;
        end
      end else if (abs_lat > {17'd0, cfg.break_threshold}) begin
        nxt.stable_state     = 1'b0;
        nxt.reference_weight = filt;
        nxt.window_start_ms  = item.now_ms;
      end
    end
  end

  assign res.filtered_weight = nxt.filter_value;
  assign res.stable_value    = nxt.stable_state ? nxt.latched_weight : '0;
  assign res.stable_flag     = nxt.stable_state;

endmodule

@@ hw/rtl/ema_weight_stability_detector.sv @@
// ----------------------------------------------------------------------------
// ema_weight_stability_detector - EMA filter with settling detector
// Smooths weight samples and flags when the smoothed weight has settled.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one word per weight sample or tare event. tuser
//   carries the command (0 sample, 1 tare), tdata carries raw weight and a
//   millisecond timestamp. Every input word yields exactly one output word.
//   Output stream (out_*): filtered weight, latched stable weight (zero when
//   not stable) and the stable flag in tuser.
//   Path: an accepted word is held in the input register, then written from
//   the update datapath into the result register, which drives out_tvalid.
//   Throughput: one word per cycle while out_tready stays high; the state
//   feedback loop (one 33x17 multiply, add and compare) is combinational.
//   Stall: a full result register that is not taken holds; one more word
//   is still taken into the input register, after which in_tready drops.
//   Reset (rst_n low, synchronous): registers return to their defaults,
//   filter state clears, the next sample loads the filter directly.
//   Configuration: APB writes, to be done only while the stream is idle.
// ----------------------------------------------------------------------------
module ema_weight_stability_detector (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [63:0]                 in_tdata,   // raw_weight[31:0], now_ms[63:32]
  input  logic                        in_tuser,   // command
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [63:0]                 out_tdata,  // filtered_weight[31:0], stable_value[63:32]
  output logic                        out_tuser,  // stable_flag
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ewsd_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import ewsd_pkg::*;

  cfg_t     cfg_r;
  state_t   state_r;
  state_t   state_nxt;
  item_t    s1_item_r;
  logic     s1_valid_r;
  logic     out_valid_r;
  result_t  out_res_r;
  result_t  res_nxt;
  reg_idx_t cfg_idx;
  logic     cfg_wr;
  logic     s1_move;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha_q16        <= ALPHA_RST;
      cfg_r.settle_threshold <= SETTLE_RST;
      cfg_r.break_threshold  <= BREAK_RST;
      cfg_r.settle_time_ms   <= STIME_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ALPHA:  cfg_r.alpha_q16        <= cfg_pwdata[15:0];
        REG_SETTLE: cfg_r.settle_threshold <= cfg_pwdata[15:0];
        REG_BREAK:  cfg_r.break_threshold  <= cfg_pwdata[15:0];
        REG_STIME:  cfg_r.settle_time_ms   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ALPHA:  cfg_prdata = {16'd0, cfg_r.alpha_q16};
      REG_SETTLE: cfg_prdata = {16'd0, cfg_r.settle_threshold};
      REG_BREAK:  cfg_prdata = {16'd0, cfg_r.break_threshold};
      REG_STIME:  cfg_prdata = cfg_r.settle_time_ms;
      default:    cfg_prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  // word in s1 moves to the result register when that register frees up
  assign s1_move   = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.command    <= in_tuser;
      s1_item_r.raw_weight <= in_tdata[31:0];
      s1_item_r.now_ms     <= in_tdata[63:32];
    end
  end

  // ---------------- update datapath ----------------
  ewsd_core u_core (
    .cfg  (cfg_r),
    .cur  (state_r),
    .item (s1_item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // filter state only advances when a word commits to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.filter_value     <= '0;
      state_r.first_pending    <= 1'b1;
      state_r.reference_weight <= '0;
      state_r.window_start_ms  <= '0;
      state_r.stable_state     <= 1'b0;
      state_r.latched_weight   <= '0;
    end else if (s1_move) begin
      state_r <= state_nxt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.stable_value, out_res_r.filtered_weight};
  assign out_tuser  = out_res_r.stable_flag;

endmodule

@@ sim/ema_weight_stability_detector_tb.sv @@
// ----------------------------------------------------------------------------
// ema_weight_stability_detector_tb - self-checking bench for the EMA detector
// Drives sample and tare words with random gaps and back-pressure, keeps its
// own copy of the filter, settle window and stability latch, and compares
// each result word field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module ema_weight_stability_detector_tb;
  import ewsd_pkg::*;

  // generous ceiling for ~1500 words at worst-case source gap plus sink stall;
  // drains and APB writes add little
  localparam int unsigned CYCLE_LIMIT = 400000;
  // extra cycles after the last expected word (input and result registers plus margin)
  localparam int unsigned PIPE_SLACK  = 4;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_WORDS = 110;
  localparam int unsigned SHOW_LIMIT  = 10;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [63:0]       in_tdata    = '0;    // raw_weight[31:0], now_ms[63:32]
  logic              in_tuser    = 1'b0;  // command
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [63:0]       out_tdata;           // filtered_weight[31:0], stable_value[63:32]
  logic              out_tuser;           // stable_flag
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]       cfg_pwdata  = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  ema_weight_stability_detector u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scale model: register copies and detector state
  // --------------------------------------------------------------------------
  logic        [15:0] alpha_reg;
  logic        [15:0] settle_thr_reg;
  logic        [15:0] break_thr_reg;
  logic        [31:0] settle_ms_reg;

  logic signed [31:0] ema_filter;
  logic               load_pending;     // next sample loads the filter directly
  logic signed [31:0] settle_ref;
  logic        [31:0] window_start;
  logic               is_stable;
  logic signed [31:0] latched_wt;

  result_t            expected_weights[$];
  int unsigned        mismatch_cnt = 0;
  int unsigned        cycle_cnt    = 0;
  bit                 src_idle_on  = 1'b0;
  bit                 sink_idle_on = 1'b0;
  int unsigned        sink_hold    = 0;
  logic        [31:0] clock_ms     = '0;  // running timestamp for stimulus

  task automatic reset_scale_model();
    alpha_reg      = ALPHA_RST;
    settle_thr_reg = SETTLE_RST;
    break_thr_reg  = BREAK_RST;
    settle_ms_reg  = STIME_RST;
    ema_filter     = '0;
    load_pending   = 1'b1;
    settle_ref     = '0;
    window_start   = '0;
    is_stable      = 1'b0;
    latched_wt     = '0;
  endtask

  // |a - b| at 33 bits, no wrap
  function automatic logic [32:0] abs_gap(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return d[32] ? -d : d;
  endfunction

  function automatic result_t step_scale_model(input item_t w);
    logic signed [32:0] diff;
    logic signed [49:0] prod;
    logic signed [49:0] move;
    result_t            r;
    if (w.command == CMD_TARE) begin
      // filter and latched weight survive a tare
      load_pending = 1'b1;
      is_stable    = 1'b0;
      settle_ref   = '0;
      window_start = w.now_ms;
    end else begin
      if (load_pending) begin
        ema_filter   = w.raw_weight;
        load_pending = 1'b0;
      end else begin
        diff       = $signed({w.raw_weight[31], w.raw_weight})
                   - $signed({ema_filter[31], ema_filter});
        prod       = diff * $signed({1'b0, alpha_reg});
        move       = prod >>> 16;   // floor
        ema_filter = ema_filter + move[31:0];
      end

      if (!is_stable) begin
        if (abs_gap(ema_filter, settle_ref) > {17'd0, settle_thr_reg}) begin
          // still moving: restart the window
          settle_ref   = ema_filter;
          window_start = w.now_ms;
        end else if ((w.now_ms - window_start) > settle_ms_reg) begin
          is_stable  = 1'b1;
          latched_wt = ema_filter;
        end
      end else if (abs_gap(ema_filter, latched_wt) > {17'd0, break_thr_reg}) begin
        is_stable    = 1'b0;
        settle_ref   = ema_filter;
        window_start = w.now_ms;
      end
    end
    r.filtered_weight = ema_filter;
    r.stable_value    = is_stable ? latched_wt : '0;
    r.stable_flag     = is_stable;
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(input bit on);
    int unsigned r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and the checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (sink_hold != 0) begin
      out_tready <= 1'b0;
      sink_hold  <= sink_hold - 1;
    end else begin
      out_tready <= 1'b1;
      sink_hold  <= pick_gap(sink_idle_on);
    end
  end

  always @(posedge clk) begin : check_words
    result_t exp_w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_weights.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= SHOW_LIMIT)
          $display("[%0d] unexpected result word: tdata=%h tuser=%b",
                   cycle_cnt, out_tdata, out_tuser);
      end else begin
        exp_w = expected_weights.pop_front();
        if (out_tdata[31:0]  !== exp_w.filtered_weight ||
            out_tdata[63:32] !== exp_w.stable_value ||
            out_tuser        !== exp_w.stable_flag) begin
          mismatch_cnt++;
          if (mismatch_cnt <= SHOW_LIMIT)
            $display("[%0d] mismatch: filtered exp %h got %h, stable_value exp %h got %h,",
                     cycle_cnt, exp_w.filtered_weight, out_tdata[31:0],
                     exp_w.stable_value, out_tdata[63:32],
                     " stable_flag exp %b got %b", exp_w.stable_flag, out_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Offer one word, wait for the handshake, predict, then maybe idle.
  // tvalid stays high when no gap follows.
  task automatic send_word(input logic cmd, input logic [31:0] raw,
                           input logic [31:0] now);
    item_t       w;
    int unsigned gap;
    w.command    = cmd;
    w.raw_weight = raw;
    w.now_ms     = now;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {now, raw};
    do @(posedge clk); while (!in_tready);
    expected_weights.push_back(step_scale_model(w));
    gap = pick_gap(src_idle_on);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the source until every predicted word has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_weights.size() != 0) @(posedge clk);
  endtask

  // APB write: setup phase, access phase, then back to idle
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ALPHA:  alpha_reg      = val[15:0];
      REG_SETTLE: settle_thr_reg = val[15:0];
      REG_BREAK:  break_thr_reg  = val[15:0];
      REG_STIME:  settle_ms_reg  = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [15:0] alpha, input logic [15:0] settle,
                               input logic [15:0] brk, input logic [31:0] stime);
    drain_results();
    repeat (PIPE_SLACK) @(posedge clk);
    write_reg(REG_ALPHA,  {16'd0, alpha});
    write_reg(REG_SETTLE, {16'd0, settle});
    write_reg(REG_BREAK,  {16'd0, brk});
    write_reg(REG_STIME,  stime);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset settings: first load, settle latch, small drift, break, tare.
  task automatic test_settle_and_break();
    send_word(CMD_SAMPLE, 32'd25600, 32'd1000);          // 100 g loads directly
    send_word(CMD_SAMPLE, 32'd25600, 32'd2000);          // inside window
    send_word(CMD_SAMPLE, 32'd25600, 32'd2501);          // 1501 ms -> stable
    send_word(CMD_SAMPLE, 32'd27600, 32'd2600);          // drift under break
    send_word(CMD_SAMPLE, 32'd30600, 32'd2700);          // beyond break
    send_word(CMD_TARE,   $urandom, 32'd2800);
    send_word(CMD_SAMPLE, 32'hFFFF_CE00, 32'd2900);      // -50 g after tare
  endtask

  // Full-scale weights, timestamp wrap across the settle window.
  task automatic test_field_extremes();
    send_word(CMD_SAMPLE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_SAMPLE, 32'h8000_0000, 32'h0000_0000); // full negative swing
    send_word(CMD_SAMPLE, 32'h7FFF_FFFF, 32'h0000_0010);
    send_word(CMD_TARE,   32'h8000_0000, 32'hFFFF_FF00);
    send_word(CMD_SAMPLE, 32'h8000_0000, 32'hFFFF_FF10); // loads most negative
    send_word(CMD_SAMPLE, 32'h8000_0000, 32'h0000_0600); // wrapped elapsed
    send_word(CMD_SAMPLE, 32'h7FFF_FFFF, 32'h0000_0700); // 33-bit difference
    send_word(CMD_TARE,   32'h7FFF_FFFF, 32'h0000_0800);
  endtask

  // Alpha 0 freezes after the first load; alpha max tracks the raw value.
  task automatic test_alpha_extremes();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    load_settings(16'd0, 16'd0, 16'd0, 32'd0);
    send_word(CMD_SAMPLE, 32'd2560,  32'd5000);
    send_word(CMD_SAMPLE, 32'd128000, 32'd5000);         // frozen, zero elapsed
    send_word(CMD_SAMPLE, 32'hFFF0_0000, 32'd5001);      // latches
    send_word(CMD_SAMPLE, 32'd2561, 32'd5002);
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(CMD_SAMPLE, 32'h8000_0000, 32'd6000);
    send_word(CMD_SAMPLE, 32'h7FFF_FFFF, 32'd6001);
    send_word(CMD_SAMPLE, 32'hFFFF_FF00, 32'd6002);
    send_word(CMD_TARE,   32'd0,         32'd6003);
  endtask

  // Phases of random settings. Most words form settle runs (optional tare,
  // then noisy samples around one level with advancing time), some are
  // jumps around the break threshold, the rest is unconstrained noise.
  task automatic test_random_phases();
    int unsigned        p;
    int unsigned        sent;
    int unsigned        r;
    int unsigned        k;
    int unsigned        run_len;
    int unsigned        amp;
    int unsigned        span;
    logic signed [31:0] level;
    for (p = 0; p < PHASES; p++) begin
      case (p % 6)
        0: load_settings(ALPHA_RST, SETTLE_RST, BREAK_RST, STIME_RST);
        1: load_settings(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 600)),
                         16'($urandom_range(0, 2000)), $urandom_range(0, 3000));
        2: load_settings(16'hFFFF, 16'd0, 16'd0, 32'd0);
        3: load_settings(16'd0, 16'hFFFF, 16'hFFFF, $urandom_range(0, 500));
        4: load_settings(16'($urandom), 16'($urandom), 16'($urandom), $urandom);
        default: load_settings(16'($urandom), 16'($urandom_range(0, 300)),
                               16'($urandom_range(0, 1000)), 32'hFFFF_FFFF);
      endcase
      // some phases run without any idling on one or both sides
      src_idle_on  = (p % 4) != 0;
      sink_idle_on = (p % 3) != 1;
      if (p == 7) clock_ms = 32'hFFFF_F000;   // cross the timestamp wrap
      level = '0;
      sent  = 0;
      while (sent < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          if ($urandom_range(0, 1) != 0) begin
            send_word(CMD_TARE, $urandom, clock_ms);
            sent++;
          end
          level   = 32'($urandom_range(0, 32'h1FFF_FFFF)) - 32'h1000_0000;
          amp     = $urandom_range(0, int'(settle_thr_reg) + 8);
          run_len = $urandom_range(4, 30);
          for (k = 0; k < run_len; k++) begin
            clock_ms = clock_ms + $urandom_range(0, 300);
            send_word(CMD_SAMPLE, level + 32'($urandom_range(0, 2 * amp)) - 32'(amp),
                      clock_ms);
            sent++;
          end
        end else if (r < 88) begin
          span = int'(break_thr_reg) + 16;
          for (k = 0; k < 3; k++) begin
            clock_ms = clock_ms + $urandom_range(0, 300);
            send_word(CMD_SAMPLE, level + 32'($urandom_range(0, 4 * span)) - 32'(2 * span),
                      clock_ms);
            sent++;
          end
        end else begin
          // now and then the source waits for the pipe to empty completely
          if ($urandom_range(0, 9) == 0) drain_results();
          send_word(1'($urandom_range(0, 1)), $urandom, $urandom);
          sent++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_scale_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_settle_and_break();
    test_field_extremes();
    test_alpha_extremes();
    test_random_phases();

    drain_results();
    repeat (2 * PIPE_SLACK) @(posedge clk);   // catch stray extra words

    if (mismatch_cnt == 0 && expected_weights.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ewsd_pkg.sv
hw/rtl/ewsd_core.sv
hw/rtl/ema_weight_stability_detector.sv
sim/ema_weight_stability_detector_tb.sv
